/* design/crc8fcs_pkg.sv */
package crc8fcs_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] OP_PING     = 8'h10;
  localparam logic [7:0] OP_LAMP_ON  = 8'h30;
  localparam logic [7:0] OP_LAMP_OFF = 8'h31;
  localparam logic [7:0] REPLY_FLAG  = 8'h80;
  localparam logic [7:0] PING_VALUE  = 8'h55;
  localparam logic [7:0] REPLY_COUNT = 8'h01;
  localparam int         QUEUE_DEPTH = 2;

  localparam logic [2:0] IDX_SYNC  = 3'd0;
  localparam logic [2:0] IDX_ADDR  = 3'd1;
  localparam logic [2:0] IDX_OP    = 3'd2;
  localparam logic [2:0] IDX_COUNT = 3'd3;
  localparam logic [2:0] IDX_VALUE = 3'd4;
  localparam logic [2:0] IDX_CRC   = 3'd5;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_ADDR,
    ST_CMD,
    ST_LEN,
    ST_PAYLOAD,
    ST_CHECK
  } frame_state_t;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_LAMP_ON,
    CMD_LAMP_OFF
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] reply_opcode(input cmd_t cmd);
    logic [7:0] op;
    unique case (cmd)
      CMD_ECHO:     op = OP_PING;
      CMD_LAMP_ON:  op = OP_LAMP_ON;
      CMD_LAMP_OFF: op = OP_LAMP_OFF;
      default:      op = OP_PING;
    endcase
    return op | REPLY_FLAG;
  endfunction

  function automatic logic [7:0] reply_value(input cmd_t cmd);
    logic [7:0] v;
    unique case (cmd)
      CMD_ECHO:     v = PING_VALUE;
      CMD_LAMP_ON:  v = 8'h01;
      CMD_LAMP_OFF: v = 8'h00;
      default:      v = PING_VALUE;
    endcase
    return v;
  endfunction

endpackage

/* design/crc8_framed_command_slave.sv */
// channel  direction  handshake         fields
// rx       in         push / full       rx_byte[7:0]
// tx       out        pop / empty       tx_byte[7:0], reply_last, lamp_on
// cfg      in         cfg_write         cfg_data[7:0] (own address)
//
// one received byte is taken per cycle while full is low
// a frame with good crc and known command queues a reply; its first beat shows
//   after the queue and then the reply side register it; six beats drain one per pop
// full rises only while the two-entry command queue between decode and reply is full
// rst is synchronous: hunting, lamp off, own address 1, queue empty
module crc8_framed_command_slave #(
  parameter int MAX_PAYLOAD = 27
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       reply_last,
  output logic       lamp_on,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);
  import crc8fcs_pkg::*;

  logic [7:0] own_address;
  cmd_beat_t  decoded;
  cmd_beat_t  head;
  logic       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 8'h01;
    end else if (cfg_write) begin
      own_address <= cfg_data;
    end
  end

  crc8fcs_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (push && !full),
    .rx_byte (rx_byte),
    .cmd_out (decoded)
  );

  crc8fcs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (decoded),
    .rd   (take),
    .head (head),
    .full (full)
  );

  crc8fcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .own_address (own_address),
    .head        (head),
    .take        (take),
    .pop         (pop),
    .empty       (empty),
    .tx_byte     (tx_byte),
    .reply_last  (reply_last),
    .lamp_on     (lamp_on)
  );

endmodule

/* design/crc8fcs_front.sv */
module crc8fcs_front #(
  parameter int MAX_PAYLOAD = 27
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  output crc8fcs_pkg::cmd_beat_t cmd_out
);
  import crc8fcs_pkg::*;

  frame_state_t state;
  frame_state_t state_next;
  logic [7:0]   crc;
  logic [7:0]   crc_next;
  logic [7:0]   cmd_code;
  logic [7:0]   remaining;
  logic [7:0]   fed;

  assign fed = crc_feed((state == ST_HUNT) ? CRC_INIT : crc, rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      crc <= crc_next;
      if (state == ST_CMD) begin
        cmd_code <= rx_byte;
      end
      if (state == ST_LEN) begin
        remaining <= rx_byte;
      end else if (state == ST_PAYLOAD) begin
        remaining <= remaining - 8'd1;
      end
    end
  end

  always_comb begin
    state_next    = state;
    crc_next      = fed;
    cmd_out.valid = 1'b0;
    cmd_out.cmd   = CMD_ECHO;
    if (accept) begin
      unique case (state)
        ST_HUNT: begin
          if (rx_byte == SYNC_BYTE) begin
            state_next = ST_ADDR;
          end
        end
        ST_ADDR: state_next = ST_CMD;
        ST_CMD:  state_next = ST_LEN;
        ST_LEN: begin
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            state_next = ST_HUNT;
          end else if (rx_byte == 8'd0) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (remaining == 8'd1) begin
            state_next = ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_next = ST_HUNT;
          crc_next   = crc;
          if (rx_byte == crc) begin
            cmd_out.valid = (cmd_code == OP_PING) || (cmd_code == OP_LAMP_ON)
                            || (cmd_code == OP_LAMP_OFF);
            unique case (cmd_code)
              OP_LAMP_ON:  cmd_out.cmd = CMD_LAMP_ON;
              OP_LAMP_OFF: cmd_out.cmd = CMD_LAMP_OFF;
              default:     cmd_out.cmd = CMD_ECHO;
            endcase
          end
        end
        default: state_next = ST_HUNT;
      endcase
    end
  end

endmodule

/* design/crc8fcs_queue.sv */
module crc8fcs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  crc8fcs_pkg::cmd_beat_t wr,
  input  logic                   rd,
  output crc8fcs_pkg::cmd_beat_t head,
  output logic                   full
);
  import crc8fcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_wr      = wr.valid && !full;
  assign do_rd      = rd && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr.cmd;
    end
  end

endmodule

/* design/crc8fcs_back.sv */
module crc8fcs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             own_address,
  input  crc8fcs_pkg::cmd_beat_t head,
  output logic                   take,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             tx_byte,
  output logic                   reply_last,
  output logic                   lamp_on
);
  import crc8fcs_pkg::*;

  logic       busy;
  logic [2:0] idx;
  cmd_t       op;
  logic [7:0] crc;
  logic       lamp;
  logic       beat;

  assign empty      = !busy;
  assign beat       = pop && busy;
  assign reply_last = (idx == IDX_CRC);
  assign lamp_on    = lamp;
  assign take       = head.valid && (!busy || (beat && reply_last));

  always_comb begin
    unique case (idx)
      IDX_SYNC:  tx_byte = SYNC_BYTE;
      IDX_ADDR:  tx_byte = own_address;
      IDX_OP:    tx_byte = reply_opcode(op);
      IDX_COUNT: tx_byte = REPLY_COUNT;
      IDX_VALUE: tx_byte = reply_value(op);
      IDX_CRC:   tx_byte = crc;
      default:   tx_byte = crc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_SYNC;
      lamp <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        idx  <= IDX_SYNC;
        if (head.cmd == CMD_LAMP_ON) begin
          lamp <= 1'b1;
        end else if (head.cmd == CMD_LAMP_OFF) begin
          lamp <= 1'b0;
        end
      end else if (beat) begin
        if (reply_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op  <= head.cmd;
      crc <= CRC_INIT;
    end else if (beat) begin
      crc <= crc_feed(crc, tx_byte);
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= IDX_CRC))
    else $error("reply index past last beat");
  a_lamp_set: assert property (@(posedge clk) disable iff (rst)
    (take && head.cmd == CMD_LAMP_ON) |=> (lamp && busy && idx == IDX_SYNC))
    else $error("lamp not lit on lamp-on command");
  a_step: assert property (@(posedge clk) disable iff (rst)
    (beat && !reply_last) |=> (busy && idx == $past(idx) + 3'd1))
    else $error("reply beat did not advance");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (beat && reply_last && !head.valid) |=> empty)
    else $error("reply did not finish");
`endif

endmodule

/* bench/crc8_reply_checker.sv */
`timescale 1ns / 100ps

module crc8_reply_checker #(
  parameter int MAX_PAYLOAD = 27
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] rx_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] tx_byte,
  input  logic       reply_last,
  input  logic       lamp_on,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         pending
);
  import crc8fcs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       lamp;
  } reply_beat_t;

  reply_beat_t  replies_due[$];
  frame_state_t phase;
  logic [7:0]   frame_crc;
  logic [7:0]   cmd_code;
  logic [7:0]   payload_left;
  logic [7:0]   own_addr;
  logic         lamp;

  // msb-first, one message bit at a time
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    int         i;
    r = acc;
    for (i = 7; i >= 0; i--) begin
      if (r[7] ^ din[i]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic queue_reply(input logic [7:0] value);
    logic [7:0]  bytes [6];
    logic [7:0]  acc;
    reply_beat_t beat;
    int          k;
    bytes[0] = SYNC_BYTE;
    bytes[1] = own_addr;
    bytes[2] = cmd_code | REPLY_FLAG;
    bytes[3] = REPLY_COUNT;
    bytes[4] = value;
    acc = CRC_INIT;
    for (k = 0; k < 5; k++) acc = crc8_next(acc, bytes[k]);
    bytes[5] = acc;
    for (k = 0; k < 6; k++) begin
      beat.data = bytes[k];
      beat.last = (k == 5);
      beat.lamp = lamp;
      replies_due.push_back(beat);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    case (phase)
      ST_HUNT: begin
        if (b == SYNC_BYTE) begin
          frame_crc = crc8_next(CRC_INIT, b);
          phase = ST_ADDR;
        end
      end
      ST_ADDR: begin
        frame_crc = crc8_next(frame_crc, b);
        phase = ST_CMD;
      end
      ST_CMD: begin
        cmd_code = b;
        frame_crc = crc8_next(frame_crc, b);
        phase = ST_LEN;
      end
      ST_LEN: begin
        if (b > MAX_PAYLOAD) begin
          phase = ST_HUNT;
        end else begin
          payload_left = b;
          frame_crc = crc8_next(frame_crc, b);
          phase = (b == 0) ? ST_CHECK : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        frame_crc = crc8_next(frame_crc, b);
        payload_left--;
        if (payload_left == 0) phase = ST_CHECK;
      end
      default: begin
        phase = ST_HUNT;
        if (b == frame_crc) begin
          case (cmd_code)
            OP_PING: queue_reply(PING_VALUE);
            OP_LAMP_ON: begin
              lamp = 1'b1;
              queue_reply(8'h01);
            end
            OP_LAMP_OFF: begin
              lamp = 1'b0;
              queue_reply(8'h00);
            end
            default: ;
          endcase
        end
      end
    endcase
  endtask

  task automatic check_beat();
    reply_beat_t due;
    if (replies_due.size() == 0) begin
      errors++;
      $display("%0t: tx beat with none due, expected nothing, actual %h last %b lamp %b",
               $time, tx_byte, reply_last, lamp_on);
    end else begin
      due = replies_due.pop_front();
      if (tx_byte !== due.data) begin
        errors++;
        $display("%0t: tx_byte mismatch, expected %h actual %h", $time, due.data, tx_byte);
      end
      if (reply_last !== due.last) begin
        errors++;
        $display("%0t: reply_last mismatch, expected %b actual %b", $time, due.last,
                 reply_last);
      end
      if (lamp_on !== due.lamp) begin
        errors++;
        $display("%0t: lamp_on mismatch, expected %b actual %b", $time, due.lamp, lamp_on);
      end
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      replies_due.delete();
      phase = ST_HUNT;
      frame_crc = CRC_INIT;
      cmd_code = 8'h00;
      payload_left = 8'h00;
      own_addr = 8'h01;
      lamp = 1'b0;
    end else begin
      if (cfg_write) own_addr = cfg_data;
      if (pop && !empty) check_beat();
      if (push && !full) absorb_byte(rx_byte);
    end
    pending = replies_due.size();
  end

endmodule

/* bench/tb_crc8_framed_command_slave.sv */
`timescale 1ns / 100ps

module tb_crc8_framed_command_slave;
  import crc8fcs_pkg::*;

  localparam int MAX_PAYLOAD = 27;
  localparam int STALL_LIMIT = 600;

  typedef enum {TAIL_NONE, TAIL_GOOD, TAIL_BAD} tail_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] tx_byte;
  logic       reply_last;
  logic       lamp_on;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  int         errors;
  int         pending;

  logic [7:0] fbytes[$];
  int         sent = 0;
  int         send_calm = 0;
  int         pop_hold = 0;
  int         pop_calm = 0;
  int         idle_cycles;
  bit         idle_on = 1'b1;

  crc8_framed_command_slave #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .tx_byte(tx_byte), .reply_last(reply_last),
    .lamp_on(lamp_on), .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  crc8_reply_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .tx_byte(tx_byte), .reply_last(reply_last),
    .lamp_on(lamp_on), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] frame_crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    int         k;
    c = acc ^ b;
    for (k = 0; k < 8; k++) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && send_calm == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
      send_calm = $urandom_range(0, 40);
    end else if (send_calm > 0) begin
      send_calm--;
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    sent++;
    @(negedge clk);
  endtask

  task automatic frame_head(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] len);
    fbytes.push_back(SYNC_BYTE);
    fbytes.push_back(addr);
    fbytes.push_back(cmd);
    fbytes.push_back(len);
  endtask

  task automatic send_frame(input tail_t tail);
    logic [7:0] acc;
    logic [7:0] flip;
    int         i;
    if (tail != TAIL_NONE) begin
      acc = CRC_INIT;
      for (i = 0; i < fbytes.size(); i++) acc = frame_crc_step(acc, fbytes[i]);
      flip = 8'($urandom_range(1, 255));
      fbytes.push_back(tail == TAIL_BAD ? acc ^ flip : acc);
    end
    for (i = 0; i < fbytes.size(); i++) send_byte(fbytes[i]);
    fbytes.delete();
  endtask

  task automatic set_address(input logic [7:0] addr);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= addr;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_frame();
    int         r;
    int         n;
    int         i;
    logic [7:0] op;
    logic [7:0] len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // line noise while hunting
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) fbytes.push_back(8'($urandom_range(0, 255)));
      send_frame(TAIL_NONE);
    end else if (r < 13) begin
      frame_head(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      send_frame(TAIL_NONE);
    end else if (r < 16) begin
      // cut short, the next frame lands inside this one
      len = 8'($urandom_range(1, 6));
      frame_head(8'($urandom_range(0, 255)), OP_PING, len);
      n = $urandom_range(0, len - 1);
      for (i = 0; i < n; i++) fbytes.push_back(8'($urandom_range(0, 255)));
      send_frame(TAIL_NONE);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_PING;
      else if (r < 58) op = OP_LAMP_ON;
      else if (r < 86) op = OP_LAMP_OFF;
      else op = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) len = 8'($urandom_range(0, 4));
      else len = 8'($urandom_range(0, MAX_PAYLOAD));
      frame_head(8'($urandom_range(0, 255)), op, len);
      for (i = 0; i < len; i++) fbytes.push_back(8'($urandom_range(0, 255)));
      send_frame(($urandom_range(0, 99) < 85) ? TAIL_GOOD : TAIL_BAD);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        pop <= 1'b1;
      end else if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (pop_calm > 0) begin
        pop <= 1'b1;
        pop_calm--;
      end else begin
        pop <= 1'b1;
        pop_hold = $urandom_range(1, 14);
        pop_calm = $urandom_range(0, 40);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int         ph;
    int         target;
    logic [7:0] addr;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames at the reset address
    send_byte(8'h3C);
    frame_head(8'h00, OP_PING, 8'h00);
    send_frame(TAIL_GOOD);
    frame_head(8'hFF, OP_LAMP_ON, 8'h02);
    fbytes.push_back(SYNC_BYTE);
    fbytes.push_back(8'hFF);
    send_frame(TAIL_GOOD);
    frame_head(8'h5A, OP_LAMP_OFF, 8'hFF);
    send_frame(TAIL_NONE);
    frame_head(8'h01, OP_LAMP_OFF, 8'h00);
    send_frame(TAIL_BAD);
    frame_head(8'h02, 8'h00, 8'h01);
    fbytes.push_back(8'h00);
    send_frame(TAIL_GOOD);
    frame_head(8'h03, OP_LAMP_OFF, 8'h00);
    send_frame(TAIL_GOOD);

    for (ph = 0; ph < 5; ph++) begin
      if (ph == 0) addr = 8'hFF;
      else if (ph == 1) addr = 8'h00;
      else addr = 8'($urandom_range(0, 255));
      set_address(addr);
      if (ph == 4) idle_on = 1'b0;
      target = sent + 82;
      while (sent < target) random_frame();
    end

    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* crc8_framed_command_slave.f */
design/crc8fcs_pkg.sv
design/crc8fcs_front.sv
design/crc8fcs_queue.sv
design/crc8fcs_back.sv
design/crc8_framed_command_slave.sv
bench/crc8_reply_checker.sv
bench/tb_crc8_framed_command_slave.sv
